[rtl/fcsmh_pkg.sv]
// ----------------------------------------------------------------------------
// fcsmh_pkg
// Shared types and constants for the floppy card select / motor hold logic.
// ----------------------------------------------------------------------------
package fcsmh_pkg;

    localparam int unsigned TICKS_W = 24;
    localparam logic [TICKS_W-1:0] TICKS_RESET = 24'd4230;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 16;

    typedef enum logic [1:0] {
        OP_WRITE_BIT = 2'd0,
        OP_READ      = 2'd1,
        OP_TICK      = 2'd2,
        OP_LINE      = 2'd3
    } opcode_t;

    // register bit positions
    localparam logic [2:0] BIT_STROBE = 3'd1;
    localparam logic [2:0] BIT_HOLD   = 3'd2;
    localparam logic [2:0] BIT_DRIVE0 = 3'd4;
    localparam logic [2:0] BIT_DRIVE1 = 3'd5;
    localparam logic [2:0] BIT_DRIVE2 = 3'd6;
    localparam logic [2:0] BIT_SIDE   = 3'd7;

    localparam logic [2:0] READ_STATUS = 3'd0;

    localparam logic [7:0] STATUS_BASE      = 8'h40;
    localparam logic [7:0] STATUS_SIDE      = 8'h80;
    localparam logic [7:0] STATUS_MOTOR_OFF = 8'h10;

    // flag positions in the irq/drq pair
    localparam int unsigned FLAG_IRQ = 0;
    localparam int unsigned FLAG_DRQ = 1;

    typedef struct packed {
        logic       side_written;
        logic       side_select;
        logic       drive_changed;
        logic [1:0] drive_number;
        logic       drive_valid;
        logic       card_interrupt;
        logic       cpu_halt;
        logic [7:0] read_byte;
    } result_t;

endpackage

[rtl/floppy_card_select_motor_hold.sv]
// ----------------------------------------------------------------------------
// floppy_card_select_motor_hold
// Drive/side select, motor-enable hold-off timer, CPU hold and IRQ/DRQ
// tracking for a floppy controller card. One result word per input word.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                   | tuser
//  s_      | in  | [2:0] reg_bit [3] bit_value [5:4] event | [1:0] opcode
//  m_      | out | [7:0] read_byte [8] halt [9] irq        | -
//          |     | [10] drv_valid [12:11] drv [13] drv_chg |
//          |     | [14] side [15] side_written             |
//  cfg_    | in  | cfg_wr_data[23:0] motor hold-off ticks  | -
//
// One word per cycle; each result appears the cycle after its input word.
// All state updates are one pass of logic into the state and result regs.
// s_tready is low in reset or while the result reg is full and m_tready low.
// aresetn low clears state, drops m_tvalid and blocks input.
// ----------------------------------------------------------------------------
module floppy_card_select_motor_hold (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [2:0] reg_bit, [3] bit_value, [5:4] line_event, [7:6] zero
    input  logic [fcsmh_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] opcode
    input  logic [fcsmh_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] read_byte, [8] cpu_halt, [9] card_interrupt, [10] drive_valid,
    // [12:11] drive_number, [13] drive_changed, [14] side_select,
    // [15] side_written
    output logic [fcsmh_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [fcsmh_pkg::TICKS_W-1:0]      cfg_wr_data
);
    import fcsmh_pkg::*;

    logic [TICKS_W-1:0] ticks_reg;
    logic [2:0]         select_reg,    select_next;
    logic [1:0]         drive_reg,     drive_next;
    logic               drive_vld_reg, drive_vld_next;
    logic               side_reg,      side_next;
    logic               strobe_reg,    strobe_next;
    logic               motor_reg,     motor_next;
    logic [TICKS_W-1:0] count_reg,     count_next;
    logic               hold_reg,      hold_next;
    logic [1:0]         flags_reg,     flags_next;
    logic               m_valid_reg,   m_valid_next;
    result_t            result_reg,    result_next;

    opcode_t    opcode;
    logic [2:0] reg_bit;
    logic       bit_value;
    logic [1:0] line_event;
    logic       accept;

    assign opcode     = opcode_t'(s_tuser[1:0]);
    assign reg_bit    = s_tdata[2:0];
    assign bit_value  = s_tdata[3];
    assign line_event = s_tdata[5:4];

    assign s_tready = aresetn && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;

    always_comb begin
        logic [1:0] drv;
        logic [7:0] rd;
        logic       changed;
        logic       side_wr;
        drv     = reg_bit[1:0] - 2'd0;
        rd      = '0;
        changed = 1'b0;
        side_wr = 1'b0;

        select_next    = select_reg;
        drive_next     = drive_reg;
        drive_vld_next = drive_vld_reg;
        side_next      = side_reg;
        strobe_next    = strobe_reg;
        motor_next     = motor_reg;
        count_next     = count_reg;
        hold_next      = hold_reg;
        flags_next     = flags_reg;

        unique case (opcode)
            OP_WRITE_BIT: begin
                unique case (reg_bit)
                    BIT_STROBE: begin
                        if (bit_value && !strobe_reg) begin
                            motor_next = 1'b1;
                            count_next = ticks_reg;
                        end
                        strobe_next = bit_value;
                    end
                    BIT_HOLD: begin
                        hold_next = bit_value;
                    end
                    BIT_DRIVE0, BIT_DRIVE1, BIT_DRIVE2: begin
                        // drive index is the low two bits of bits 4..6
                        if (bit_value) begin
                            select_next[drv] = 1'b1;
                            if (!drive_vld_reg || drive_reg != drv) begin
                                drive_next     = drv;
                                drive_vld_next = 1'b1;
                                changed        = 1'b1;
                            end
                        end else begin
                            select_next[drv] = 1'b0;
                            if (drive_vld_reg && drive_reg == drv) begin
                                drive_next     = '0;
                                drive_vld_next = 1'b0;
                            end
                        end
                    end
                    BIT_SIDE: begin
                        side_next = bit_value;
                        side_wr   = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            OP_READ: begin
                if (reg_bit == READ_STATUS) begin
                    rd = STATUS_BASE | (side_reg ? STATUS_SIDE : 8'h00);
                    if (motor_reg) begin
                        rd = rd | {4'b0, select_reg, 1'b0};
                    end else begin
                        rd = rd | STATUS_MOTOR_OFF;
                    end
                end
            end
            OP_TICK: begin
                if (motor_reg) begin
                    if (count_reg[TICKS_W-1:1] == '0) begin
                        count_next = '0;
                        motor_next = 1'b0;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            OP_LINE: begin
                flags_next[line_event[1]] = line_event[0];
            end
            default: begin
            end
        endcase

        result_next.read_byte      = rd;
        result_next.cpu_halt       = hold_next && (flags_next == 2'b00) && motor_next;
        result_next.card_interrupt = flags_next[FLAG_IRQ];
        result_next.drive_valid    = drive_vld_next;
        result_next.drive_number   = drive_vld_next ? drive_next : 2'd0;
        result_next.drive_changed  = changed;
        result_next.side_select    = side_next;
        result_next.side_written   = side_wr;

        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg     <= TICKS_RESET;
            select_reg    <= '0;
            drive_reg     <= '0;
            drive_vld_reg <= 1'b0;
            side_reg      <= 1'b0;
            strobe_reg    <= 1'b0;
            motor_reg     <= 1'b0;
            count_reg     <= '0;
            hold_reg      <= 1'b0;
            flags_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ticks_reg <= cfg_wr_data;
            end
            if (accept) begin
                select_reg    <= select_next;
                drive_reg     <= drive_next;
                drive_vld_reg <= drive_vld_next;
                side_reg      <= side_next;
                strobe_reg    <= strobe_next;
                motor_reg     <= motor_next;
                count_reg     <= count_next;
                hold_reg      <= hold_next;
                flags_reg     <= flags_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

endmodule

[rtl/fcsmh_checker.sv]
// ----------------------------------------------------------------------------
// fcsmh_checker
// Port-level checks for floppy_card_select_motor_hold, bound to the top.
// ----------------------------------------------------------------------------
module fcsmh_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [fcsmh_pkg::S_TDATA_W-1:0]    s_tdata,
    input logic [fcsmh_pkg::S_TUSER_W-1:0]    s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [fcsmh_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                               cfg_wr_en,
    input logic [fcsmh_pkg::TICKS_W-1:0]      cfg_wr_data
);
    import fcsmh_pkg::*;

    result_t res;
    logic    s_acc;

    assign res   = m_tdata;
    assign s_acc = s_tvalid && s_tready;

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // only reads of the status byte give a nonzero read byte
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tuser != OP_READ || s_tdata[2:0] != READ_STATUS)
        |=> res.read_byte == 8'h00)
        else $error("nonzero read byte without a status read");

    // status read always carries the base bit and matches the side
    a_rd_base: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser == OP_READ && s_tdata[2:0] == READ_STATUS
        |=> res.read_byte[6] && res.read_byte[7] == res.side_select)
        else $error("bad status byte");

    // select/side pulses only come from register writes
    a_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser != OP_WRITE_BIT
        |=> !res.drive_changed && !res.side_written)
        else $error("select pulse without a register write");

    // halt needs irq clear, and no drive means drive number zero
    a_halt_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res.cpu_halt && res.card_interrupt)
                     && (res.drive_valid || res.drive_number == 2'd0))
        else $error("inconsistent result word");

endmodule

bind floppy_card_select_motor_hold fcsmh_checker u_fcsmh_checker (.*);

[tb/tb_floppy_card_select_motor_hold.sv]
// ----------------------------------------------------------------------------
// tb_floppy_card_select_motor_hold
// Self-checking bench for the floppy card select / motor hold logic. A short
// table of directed words (register bit writes, status reads, ticks and
// controller line events) is followed by random words over several motor
// hold-off settings. Every result word is checked field by field against an
// in-bench predictor of the card state, or against a fixed word for the
// typed directed rows. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_floppy_card_select_motor_hold;
    import fcsmh_pkg::*;

    typedef enum logic [1:0] {
        EV_IRQ_CLR = 2'd0,
        EV_IRQ_SET = 2'd1,
        EV_DRQ_CLR = 2'd2,
        EV_DRQ_SET = 2'd3
    } line_event_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CYCLIC
    } rx_mode_t;

    // register bits with no function, and a read of a byte other than status
    localparam logic [2:0] BIT_UNUSED0 = 3'd0;
    localparam logic [2:0] BIT_UNUSED3 = 3'd3;
    localparam logic [2:0] READ_HIGH   = 3'd7;

    localparam int WORDS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 5;
    localparam int IDLE_LIMIT      = 10000;

    typedef struct packed {
        opcode_t     op;
        logic [2:0]  rb;
        logic        bv;
        line_event_t ev;
        logic        typed;
        result_t     want;
    } card_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [TICKS_W-1:0]   cfg_wr_data = '0;

    // predicted card state
    logic [2:0]         sel_bits;
    logic [1:0]         cur_drive;
    logic               cur_valid;
    logic               side_q;
    logic               strobe_q;
    logic               motor_q;
    logic [TICKS_W-1:0] motor_left;
    logic               hold_q;
    logic               irq_q;
    logic               drq_q;
    logic [TICKS_W-1:0] ticks_cfg;

    result_t   card_results_due[$];
    card_row_t directed_rows[$];
    int        mismatches = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;
    rx_mode_t  rx_mode = RX_OPEN;
    int        rx_left = 0;
    int        rx_phase = 0;

    floppy_card_select_motor_hold dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic result_t apply_card_word(opcode_t op, logic [2:0] rb, logic bv,
                                                line_event_t ev);
        result_t    r;
        logic [1:0] drv;
        r = '0;
        drv = 2'(rb - BIT_DRIVE0);
        case (op)
            OP_WRITE_BIT: begin
                case (rb)
                    BIT_STROBE: begin
                        if (bv && !strobe_q) begin
                            motor_q = 1'b1;
                            motor_left = ticks_cfg;
                        end
                        strobe_q = bv;
                    end
                    BIT_HOLD: hold_q = bv;
                    BIT_DRIVE0, BIT_DRIVE1, BIT_DRIVE2: begin
                        sel_bits[drv] = bv;
                        if (bv && !(cur_valid && cur_drive == drv)) begin
                            cur_drive = drv;
                            cur_valid = 1'b1;
                            r.drive_changed = 1'b1;
                        end else if (!bv && cur_valid && cur_drive == drv) begin
                            cur_valid = 1'b0;
                            cur_drive = 2'd0;
                        end
                    end
                    BIT_SIDE: begin
                        side_q = bv;
                        r.side_written = 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_READ: begin
                if (rb == READ_STATUS)
                    r.read_byte = STATUS_BASE | (side_q ? STATUS_SIDE : 8'h00) |
                                  (motor_q ? {4'b0000, sel_bits, 1'b0} : STATUS_MOTOR_OFF);
            end
            OP_TICK: begin
                if (motor_q) begin
                    if (motor_left <= 1) begin
                        motor_left = '0;
                        motor_q = 1'b0;
                    end else begin
                        motor_left = motor_left - 1'b1;
                    end
                end
            end
            default: begin
                // bit 1 picks DRQ over IRQ, bit 0 is the new level
                if (ev[1])
                    drq_q = ev[0];
                else
                    irq_q = ev[0];
            end
        endcase
        r.cpu_halt = hold_q && motor_q && !irq_q && !drq_q;
        r.card_interrupt = irq_q;
        r.drive_valid = cur_valid;
        r.drive_number = cur_valid ? cur_drive : 2'd0;
        r.side_select = side_q;
        return r;
    endfunction

    function automatic void add_row(opcode_t op, logic [2:0] rb, logic bv, line_event_t ev,
                                    logic typed = 1'b0, result_t want = '0);
        card_row_t row;
        row.op = op;
        row.rb = rb;
        row.bv = bv;
        row.ev = ev;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    task automatic send_card_word(opcode_t op, logic [2:0] rb, logic bv, line_event_t ev,
                                  logic typed, result_t want);
        int      gap;
        result_t predicted;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, ev, bv, rb};
        s_tuser <= op;
        do @(posedge aclk); while (!s_tready);
        predicted = apply_card_word(op, rb, bv, ev);
        card_results_due.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (card_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic set_motor_ticks(logic [TICKS_W-1:0] ticks);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ticks_cfg = ticks;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (card_results_due.size() == 0) begin
                $display("%0t: result word expected none actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = card_results_due.pop_front();
                check_field("read_byte", want.read_byte, got.read_byte);
                check_field("cpu_halt", want.cpu_halt, got.cpu_halt);
                check_field("card_interrupt", want.card_interrupt, got.card_interrupt);
                check_field("drive_valid", want.drive_valid, got.drive_valid);
                check_field("drive_number", want.drive_number, got.drive_number);
                check_field("drive_changed", want.drive_changed, got.drive_changed);
                check_field("side_select", want.side_select, got.side_select);
                check_field("side_written", want.side_written, got.side_written);
            end
        end
    end

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= (rx_phase + 1) % 5;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
            default:   m_tready <= (rx_phase < 2);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        card_row_t          row;
        logic [TICKS_W-1:0] plan [NUM_PHASES];
        opcode_t            op;
        logic [2:0]         rb;
        logic               bv;
        line_event_t        ev;
        int                 pick;

        sel_bits = '0;
        cur_drive = '0;
        cur_valid = 1'b0;
        side_q = 1'b0;
        strobe_q = 1'b0;
        motor_q = 1'b0;
        motor_left = '0;
        hold_q = 1'b0;
        irq_q = 1'b0;
        drq_q = 1'b0;
        ticks_cfg = TICKS_RESET;

        add_row(OP_READ, READ_STATUS, 1'b0, EV_IRQ_CLR, 1'b1,
                result_t'(16'(STATUS_BASE | STATUS_MOTOR_OFF)));
        add_row(OP_READ, READ_HIGH, 1'b1, EV_DRQ_SET, 1'b1, '0);
        add_row(OP_WRITE_BIT, BIT_UNUSED0, 1'b1, EV_IRQ_CLR, 1'b1, '0);
        add_row(OP_WRITE_BIT, BIT_UNUSED3, 1'b1, EV_IRQ_CLR, 1'b1, '0);
        add_row(OP_TICK, READ_STATUS, 1'b0, EV_IRQ_CLR, 1'b1, '0);
        add_row(OP_WRITE_BIT, BIT_DRIVE0, 1'b1, EV_IRQ_CLR);
        add_row(OP_WRITE_BIT, BIT_DRIVE2, 1'b1, EV_IRQ_CLR);
        add_row(OP_WRITE_BIT, BIT_DRIVE2, 1'b1, EV_IRQ_CLR);
        add_row(OP_WRITE_BIT, BIT_DRIVE0, 1'b0, EV_IRQ_CLR);
        add_row(OP_WRITE_BIT, BIT_HOLD, 1'b1, EV_IRQ_CLR);
        add_row(OP_WRITE_BIT, BIT_STROBE, 1'b1, EV_IRQ_CLR);
        add_row(OP_READ, READ_STATUS, 1'b0, EV_IRQ_CLR);
        add_row(OP_WRITE_BIT, BIT_STROBE, 1'b1, EV_IRQ_CLR);
        add_row(OP_LINE, READ_STATUS, 1'b0, EV_IRQ_SET);
        add_row(OP_LINE, READ_STATUS, 1'b0, EV_DRQ_SET);
        add_row(OP_LINE, READ_STATUS, 1'b0, EV_IRQ_CLR);
        add_row(OP_LINE, READ_STATUS, 1'b0, EV_DRQ_CLR);
        add_row(OP_WRITE_BIT, BIT_SIDE, 1'b1, EV_IRQ_CLR);
        add_row(OP_WRITE_BIT, BIT_DRIVE1, 1'b1, EV_IRQ_CLR);
        add_row(OP_READ, READ_STATUS, 1'b0, EV_IRQ_CLR);
        add_row(OP_TICK, READ_STATUS, 1'b0, EV_IRQ_CLR);
        add_row(OP_WRITE_BIT, BIT_STROBE, 1'b0, EV_IRQ_CLR);
        add_row(OP_WRITE_BIT, BIT_DRIVE1, 1'b0, EV_IRQ_CLR);
        add_row(OP_WRITE_BIT, BIT_SIDE, 1'b0, EV_IRQ_CLR);
        add_row(OP_READ, 3'd3, 1'b0, EV_IRQ_CLR);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_card_word(row.op, row.rb, row.bv, row.ev, row.typed, row.want);
        end

        plan = '{24'd1, 24'hFFFFFF, 24'($urandom_range(2, 12)), 24'd3,
                 24'($urandom_range(1, 40))};
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_motor_ticks(plan[p]);
            repeat (WORDS_PER_PHASE) begin
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    op = OP_WRITE_BIT;
                else if (pick < 58)
                    op = OP_READ;
                else if (pick < 85)
                    op = OP_TICK;
                else
                    op = OP_LINE;
                rb = 3'($urandom_range(0, 7));
                if (op == OP_WRITE_BIT && $urandom_range(0, 9) < 3)
                    rb = BIT_STROBE;
                if (op == OP_READ && $urandom_range(0, 3) != 0)
                    rb = READ_STATUS;
                bv = 1'($urandom_range(0, 1));
                ev = line_event_t'($urandom_range(0, 3));
                send_card_word(op, rb, bv, ev, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
